### rtl/qvd_pkg.sv
// ----------------------------------------------------------------------------
// qvd_pkg
// Shared types and constants of the quantized vertex welding table.
// ----------------------------------------------------------------------------
package qvd_pkg;

  // Fixed field widths
  localparam int POS_W   = 20;   // signed fixed-point coordinate
  localparam int RES_W   = 11;   // grid resolution register
  localparam int QPART_W = 17;   // one quantized key part, signed
  localparam int KEY_W   = 3 * QPART_W;
  localparam int IDX_W   = 12;   // vertex index
  localparam int CNT_W   = 13;   // vertex count, holds 4096 itself
  localparam int HASH_W  = 32;

  // Index space of the vertex numbering
  localparam int INDEX_SPACE = 4096;

  // Spatial hash primes
  localparam logic [HASH_W-1:0] PRIME_X = 32'd73856093;
  localparam logic [HASH_W-1:0] PRIME_Y = 32'd19349663;
  localparam logic [HASH_W-1:0] PRIME_Z = 32'd83492791;

  // Saturation bounds of a key part
  localparam logic [QPART_W-1:0] QPART_MAX = 17'h0FFFF;  // +65535
  localparam logic [QPART_W-1:0] QPART_MIN = 17'h10000;  // -65536

  // Item function codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // One table slot as stored in memory
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   index;
  } qvd_entry_t;

  // Stage enables for the per-coordinate quantizer
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic hash_en;
  } qvd_qctl_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_QRND,
    ST_HMUL,
    ST_HASH,
    ST_MODR,
    ST_PROBE
  } qvd_state_t;

endpackage

### rtl/quantized_vertex_dedup_top.sv
// ----------------------------------------------------------------------------
// quantized_vertex_dedup_top
// Vertex welding table: quantizes a position, hashes it, looks it up by linear
// probing; known keys return their index, new keys get the next one if not full.
// ----------------------------------------------------------------------------
// An add item steps through QRND, HMUL, HASH and then PROBE once per probed
// slot (one probe at low load) before the next accept; when TABLE_DEPTH is not
// a power of two the MODR home-slot reduction runs between HASH and PROBE.
// Probing reads one slot per cycle from the single table memory. A clear item
// walks the whole memory, and the same clearing pass runs after reset; busy is
// high throughout. Each result shows on out_valid for one cycle and cannot be
// held off; busy drops in the cycle the result is shown. Configuration writes
// are always taken (cfg_ready is tied high).
module quantized_vertex_dedup_top #(
  parameter int TABLE_DEPTH     = 4096,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [qvd_pkg::POS_W-1:0]     in_pos_x,
  input  logic [qvd_pkg::POS_W-1:0]     in_pos_y,
  input  logic [qvd_pkg::POS_W-1:0]     in_pos_z,
  // result channel
  output logic                          out_valid,
  output logic [qvd_pkg::IDX_W-1:0]     out_vertex_index,
  output logic                          out_is_new,
  output logic                          out_table_full,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qvd_pkg::RES_W-1:0]     cfg_grid_resolution
);
  import qvd_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int LIMIT    = (TABLE_DEPTH < INDEX_SPACE) ? TABLE_DEPTH : INDEX_SPACE;
  localparam bit IS_POW2  = ((1 << AW) == TABLE_DEPTH);
  localparam int ENTRY_W  = $bits(qvd_entry_t);
  localparam int MT_W     = AW + 4;
  localparam logic [AW-1:0]    LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [MT_W-1:0]  DEPTH_MT  = MT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIMIT);
  localparam logic [RES_W-1:0] RES_RESET = 11'd16;

  qvd_state_t       state_r, state_nxt;
  logic [RES_W-1:0] res_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic             clr_r, clr_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    probe_r, probe_nxt;
  logic [AW-1:0]    slot_inc;
  logic [HASH_W-1:0] mod_h_r, mod_h_nxt;
  logic [AW-1:0]    mod_rem_r, mod_rem_nxt;
  logic [2:0]       mod_cnt_r, mod_cnt_nxt;
  logic [MT_W-1:0]  mod_t;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_new_r, out_new_nxt;
  logic             out_full_r, out_full_nxt;

  logic             accept;
  qvd_qctl_t        qctl;
  logic [QPART_W-1:0] qx, qy, qz;
  logic [HASH_W-1:0]  hx, hy, hz, hash;
  logic [KEY_W-1:0]   key;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  qvd_entry_t       wr_entry, rd_entry;
  logic [ENTRY_W-1:0] rd_word;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Resolution register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= RES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      res_r <= cfg_grid_resolution;
    end
  end

  // Quantizer stage enables follow the sequencer
  assign qctl.mul_en  = accept && (in_func == FUNC_ADD);
  assign qctl.rnd_en  = (state_r == ST_QRND);
  assign qctl.hash_en = (state_r == ST_HMUL);

  qvd_quant #(.FRAC_BITS(COORD_FRAC_BITS)) u_quant_x (
    .clk(clk), .ctl(qctl), .pos(in_pos_x), .res(res_r), .prime(PRIME_X),
    .q(qx), .hprod(hx)
  );
  qvd_quant #(.FRAC_BITS(COORD_FRAC_BITS)) u_quant_y (
    .clk(clk), .ctl(qctl), .pos(in_pos_y), .res(res_r), .prime(PRIME_Y),
    .q(qy), .hprod(hy)
  );
  qvd_quant #(.FRAC_BITS(COORD_FRAC_BITS)) u_quant_z (
    .clk(clk), .ctl(qctl), .pos(in_pos_z), .res(res_r), .prime(PRIME_Z),
    .q(qz), .hprod(hz)
  );

  assign key  = {qz, qy, qx};
  assign hash = hx ^ hy ^ hz;

  // Slot table
  qvd_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_entry),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_word)
  );
  assign rd_entry = qvd_entry_t'(rd_word);

  assign slot_inc = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  // Home-slot reduction, four hash bits per cycle, for non power-of-two depth
  always_comb begin
    mod_t = {mod_rem_r, mod_h_r[HASH_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (mod_t >= (DEPTH_MT << k)) begin
        mod_t = mod_t - (DEPTH_MT << k);
      end
    end
  end

  // Sequencer: next state, memory access and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sweep_nxt     = sweep_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    mod_h_nxt     = mod_h_r;
    mod_rem_nxt   = mod_rem_r;
    mod_cnt_nxt   = mod_cnt_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    wr_en         = 1'b0;
    wr_addr       = sweep_r;
    wr_entry      = '0;
    rd_en         = 1'b0;
    rd_addr       = slot_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_CLEAR) begin
            state_nxt = ST_SWEEP;
            sweep_nxt = '0;
            clr_nxt   = 1'b1;
          end else begin
            state_nxt = ST_QRND;
          end
        end
      end

      // Invalidate every slot, one per cycle
      ST_SWEEP: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
          clr_nxt   = 1'b0;
          if (clr_r) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = '0;
            out_new_nxt   = 1'b0;
            out_full_nxt  = 1'b0;
          end
        end
      end

      ST_QRND: state_nxt = ST_HMUL;
      ST_HMUL: state_nxt = ST_HASH;

      ST_HASH: begin
        probe_nxt = '0;
        if (IS_POW2) begin
          slot_nxt  = hash[AW-1:0];
          rd_en     = 1'b1;
          rd_addr   = hash[AW-1:0];
          state_nxt = ST_PROBE;
        end else begin
          mod_h_nxt   = hash;
          mod_rem_nxt = '0;
          mod_cnt_nxt = '0;
          state_nxt   = ST_MODR;
        end
      end

      ST_MODR: begin
        mod_h_nxt   = mod_h_r << 4;
        mod_rem_nxt = mod_t[AW-1:0];
        mod_cnt_nxt = mod_cnt_r + 1'b1;
        if (mod_cnt_r == 3'd7) begin
          slot_nxt  = mod_t[AW-1:0];
          rd_en     = 1'b1;
          rd_addr   = mod_t[AW-1:0];
          state_nxt = ST_PROBE;
        end
      end

      // Slot data of slot_r is on the read port
      ST_PROBE: begin
        if (!rd_entry.valid) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (cnt_r >= LIMIT_CNT) begin
            out_idx_nxt  = '0;
            out_new_nxt  = 1'b0;
            out_full_nxt = 1'b1;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = slot_r;
            wr_entry.valid = 1'b1;
            wr_entry.key   = key;
            wr_entry.index = cnt_r[IDX_W-1:0];
            out_idx_nxt    = cnt_r[IDX_W-1:0];
            out_new_nxt    = 1'b1;
            out_full_nxt   = 1'b0;
            cnt_nxt        = cnt_r + 1'b1;
          end
        end else if (rd_entry.key == key) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = rd_entry.index;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
        end else if (probe_r == LAST_SLOT) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b1;
        end else begin
          probe_nxt = probe_r + 1'b1;
          slot_nxt  = slot_inc;
          rd_en     = 1'b1;
          rd_addr   = slot_inc;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers; reset starts a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      clr_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    probe_r    <= probe_nxt;
    mod_h_r    <= mod_h_nxt;
    mod_rem_r  <= mod_rem_nxt;
    mod_cnt_r  <= mod_cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_is_new       = out_new_r;
  assign out_table_full   = out_full_r;

  // Checks
  a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_table_full))
    else $error("item marked both new and full");

  a_full_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_vertex_index == '0))
    else $error("full answer with nonzero index");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIMIT_CNT)
    else $error("vertex count above limit");

  a_new_idx_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_new) |-> (cnt_r == (CNT_W'(out_vertex_index) + 1'b1)))
    else $error("new index does not match vertex count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

endmodule

### rtl/qvd_ram.sv
// ----------------------------------------------------------------------------
// qvd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qvd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/qvd_quant.sv
// ----------------------------------------------------------------------------
// qvd_quant
// One coordinate: scale by 4*resolution, round half away from zero, saturate
// to a 17-bit key part, then form its hash product.
// ----------------------------------------------------------------------------
module qvd_quant #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  qvd_pkg::qvd_qctl_t             ctl,
  input  logic [qvd_pkg::POS_W-1:0]      pos,
  input  logic [qvd_pkg::RES_W-1:0]      res,
  input  logic [qvd_pkg::HASH_W-1:0]     prime,
  output logic [qvd_pkg::QPART_W-1:0]    q,
  output logic [qvd_pkg::HASH_W-1:0]     hprod
);
  import qvd_pkg::*;

  localparam int PROD_W = POS_W + RES_W + 2;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] LIM_P  = SUM_W'(65535);
  localparam logic [SUM_W-1:0] LIM_N  = SUM_W'(65536);

  logic [POS_W-1:0]   mag;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   qmag;
  logic [QPART_W-1:0] q_nxt;
  logic [QPART_W-1:0] q_r;
  logic [HASH_W-1:0]  qs;
  logic [HASH_W-1:0]  hprod_r;

  // Magnitude of the signed input; the most negative value maps to 2^19
  assign mag = pos[POS_W-1] ? (~pos + 1'b1) : pos;

  // Stage 1: scaled magnitude
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(mag) * PROD_W'({res, 2'b00});
      neg_r  <= pos[POS_W-1];
    end
  end

  // Stage 2: round half away from zero, saturate, restore sign
  assign sum  = SUM_W'(prod_r) + HALF;
  assign qmag = sum >> FRAC_BITS;

  always_comb begin
    if (!neg_r) begin
      q_nxt = (qmag > LIM_P) ? QPART_MAX : qmag[QPART_W-1:0];
    end else begin
      q_nxt = (qmag >= LIM_N) ? QPART_MIN : (~qmag[QPART_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rnd_en) begin
      q_r <= q_nxt;
    end
  end

  // Stage 3: hash product, sign extended, wrapped to 32 bits
  assign qs = {{(HASH_W-QPART_W){q_r[QPART_W-1]}}, q_r};

  always_ff @(posedge clk) begin
    if (ctl.hash_en) begin
      hprod_r <= qs * prime;
    end
  end

  assign q     = q_r;
  assign hprod = hprod_r;

endmodule
